@@ rtl/core/wcmv_pkg.sv @@
// Package with shared types and constants for the windowed class majority vote.
`timescale 1ns / 1ps
`default_nettype none

package wcmv_pkg;

    typedef logic [7:0] t_count;

    localparam t_count COUNT_MAX = 8'hFF;

    // Configuration register map: register index is byte address / 4.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_NO_OBJ_FRAC   = 1'b1;

    localparam logic [7:0] WINDOW_LENGTH_RST = 8'd10;
    localparam logic [8:0] NO_OBJ_FRAC_RST   = 9'd128;

    localparam int unsigned LABEL_W = 4;
    localparam int unsigned DECIDED_W = 4;

endpackage

`default_nettype wire

@@ rtl/core/windowed_class_majority_vote.sv @@
// Windowed majority vote over classifier labels with a no-object share threshold.
//
// Each accepted transaction with label_seen high either counts its label (while fewer than
// window_length samples have been taken) or, once the window is full, produces one decision
// on o_decided_class and clears all counters; the deciding transaction's label is not counted.
// Labels at or above NUM_CLASSES are ignored. The decision is class 0 when the class 0 count
// times 256 exceeds no_object_fraction (unsigned Q1.8) times window_length, otherwise the
// lowest class above 0 with the highest count, or 0 if none was counted. The block takes one
// transaction per clock cycle while o_stall is low; the running leader is kept up to date on
// every counted label, so a decision costs only one multiply and compare. A decision is
// registered in the output entry, or in the skid entry if the output entry is held. The two
// entries decouple the sides: the input stalls only when both hold results not yet taken.
// Configuration is written through the APB port: window_length at byte address 0,
// no_object_fraction at byte address 4.
`timescale 1ns / 1ps
`default_nettype none

module windowed_class_majority_vote
    import wcmv_pkg::*;
#(
    parameter int unsigned NUM_CLASSES = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_label_seen,
    input  wire logic [LABEL_W-1:0]    i_class_label,

    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DECIDED_W-1:0]       o_decided_class,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned CW = $clog2(NUM_CLASSES);
    localparam int unsigned LW = (CW > LABEL_W) ? CW : LABEL_W;

    // Configuration registers
    logic [7:0] r_window_length;
    logic [8:0] r_no_obj_frac;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RST;
            r_no_obj_frac   <= NO_OBJ_FRAC_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WINDOW_LENGTH) begin
                r_window_length <= pwdata[7:0];
            end else begin
                r_no_obj_frac <= pwdata[8:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_NO_OBJ_FRAC) begin
            prdata = {23'd0, r_no_obj_frac};
        end else begin
            prdata = {24'd0, r_window_length};
        end
    end

    // Vote state
    t_count          r_counts [NUM_CLASSES];
    t_count          n_counts [NUM_CLASSES];
    t_count          r_samples;
    t_count          n_samples;
    t_count          r_best_cnt;
    t_count          n_best_cnt;
    logic [CW-1:0]   r_best_idx;
    logic [CW-1:0]   n_best_idx;

    logic            accept;
    logic            window_full;
    logic            produce;
    logic            label_ok;
    logic [LW-1:0]   label_ext;
    logic [CW-1:0]   label_idx;
    t_count          cur_cnt;
    t_count          new_cnt;
    logic [15:0]     zero_scaled;
    logic [16:0]     limit;
    logic [LW-1:0]   best_ext;
    logic [DECIDED_W-1:0] decision;

    assign accept      = i_valid && !o_stall;
    assign window_full = (r_samples >= r_window_length);
    assign produce     = accept && i_label_seen && window_full;
    assign label_ext   = LW'(i_class_label);
    // One spare bit keeps the class count representable when it is a power of two.
    assign label_ok    = ({1'b0, label_ext} < (LW + 1)'(NUM_CLASSES));
    assign label_idx   = label_ext[CW-1:0];
    assign cur_cnt     = r_counts[label_idx];
    assign new_cnt     = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 8'd1;

    assign zero_scaled = {r_counts[0], 8'd0};
    assign limit       = 17'(r_no_obj_frac) * 17'(r_window_length);
    assign best_ext    = LW'(r_best_idx);
    assign decision    = (17'(zero_scaled) > limit) ? '0 : best_ext[DECIDED_W-1:0];

    always_comb begin
        n_counts   = r_counts;
        n_samples  = r_samples;
        n_best_cnt = r_best_cnt;
        n_best_idx = r_best_idx;
        if (accept && i_label_seen) begin
            if (window_full) begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    n_counts[k] = '0;
                end
                n_samples  = '0;
                n_best_cnt = '0;
                n_best_idx = '0;
            end else if (label_ok) begin
                n_counts[label_idx] = new_cnt;
                n_samples = (r_samples == COUNT_MAX) ? r_samples : r_samples + 8'd1;
                // Counts grow by one, so the leader is either the old one or this class.
                // Class 0 never leads; it is judged by the threshold instead.
                if (label_idx != '0) begin
                    if (new_cnt > r_best_cnt) begin
                        n_best_cnt = new_cnt;
                        n_best_idx = label_idx;
                    end else if (new_cnt == r_best_cnt && label_idx < r_best_idx) begin
                        n_best_idx = label_idx;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_counts[k] <= '0;
            end
            r_samples  <= '0;
            r_best_cnt <= '0;
            r_best_idx <= '0;
        end else begin
            r_counts   <= n_counts;
            r_samples  <= n_samples;
            r_best_cnt <= n_best_cnt;
            r_best_idx <= n_best_idx;
        end
    end

    // Output register plus skid entry
    logic                 r_out_valid;
    logic [DECIDED_W-1:0] r_out_class;
    logic                 r_skid_valid;
    logic [DECIDED_W-1:0] r_skid_class;
    logic                 out_pop;

    assign out_pop         = r_out_valid && !i_stall;
    assign o_valid         = r_out_valid;
    assign o_decided_class = r_out_class;
    assign o_stall         = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (produce) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out_class <= r_skid_class;
            end
        end else if (produce) begin
            if (!r_out_valid || out_pop) begin
                r_out_class <= decision;
            end else begin
                r_skid_class <= decision;
            end
        end
    end

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a waiting output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output entry empty");

    // After a deciding transaction the output is always valid on the next cycle.
    a_decision_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> o_valid)
        else $error("decision lost at output");

    // The leading count never exceeds the number of samples in the window.
    a_leader_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_cnt <= r_samples)
        else $error("leader count above sample count");

    // A decision clears the window.
    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> (r_samples == '0 && r_best_cnt == '0))
        else $error("window not cleared after decision");
`endif

endmodule

`default_nettype wire

@@ dv/windowed_class_majority_vote_checker.sv @@
// Checker that predicts and compares the decisions of the windowed class majority vote.
`timescale 1ns / 1ps

module windowed_class_majority_vote_checker
    import wcmv_pkg::*;
#(
    parameter int unsigned NUM_CLASSES = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic                  i_label_seen,
    input  wire logic [LABEL_W-1:0]    i_class_label,

    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [DECIDED_W-1:0]  i_decided_class,

    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]           i_pwdata,
    input  wire logic                  i_pready,

    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_decisions
);

    t_count                class_count [NUM_CLASSES];
    t_count                samples_taken;
    logic [7:0]            window_len;
    logic [8:0]            no_obj_frac;
    logic [DECIDED_W-1:0]  decision_q [$];
    int                    fail_total = 0;
    int                    decision_total = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    task automatic clear_votes();
        foreach (class_count[k]) class_count[k] = '0;
        samples_taken = '0;
    endtask

    function automatic logic [DECIDED_W-1:0] vote_winner();
        int unsigned          zero_scaled;
        int unsigned          limit;
        int unsigned          best;
        logic [DECIDED_W-1:0] winner;
        zero_scaled = 32'(class_count[0]) * 256;
        limit = 32'(no_obj_frac) * 32'(window_len);
        if (zero_scaled > limit) return '0;
        best = 0;
        winner = '0;
        // Only a strictly higher count takes over, so ties go to the lowest class.
        for (int k = 1; k < NUM_CLASSES; k++) begin
            if (32'(class_count[k]) > best) begin
                best = 32'(class_count[k]);
                winner = DECIDED_W'(k);
            end
        end
        return winner;
    endfunction

    task automatic predict_transaction(input logic seen, input logic [LABEL_W-1:0] lbl);
        if (!seen) return;
        if (samples_taken >= window_len) begin
            decision_q.push_back(vote_winner());
            clear_votes();
        end else if (lbl < NUM_CLASSES) begin
            if (class_count[lbl] != COUNT_MAX) class_count[lbl]++;
            if (samples_taken != COUNT_MAX) samples_taken++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        logic [DECIDED_W-1:0] expected_class;
        if (!i_rst_n) begin
            clear_votes();
            window_len = WINDOW_LENGTH_RST;
            no_obj_frac = NO_OBJ_FRAC_RST;
            decision_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decision_q.size() == 0) begin
                    report_mismatch($sformatf("decision %0d arrived with none outstanding",
                                              i_decided_class));
                end else begin
                    expected_class = decision_q.pop_front();
                    decision_total++;
                    if (i_decided_class !== expected_class)
                        report_mismatch($sformatf("decided_class is %0d, predicted %0d",
                                                  i_decided_class, expected_class));
                end
            end
            if (i_in_valid && !i_in_stall) predict_transaction(i_label_seen, i_class_label);
            // The register index is the byte address divided by four.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[CFG_ADDR_W-1] == REG_WINDOW_LENGTH)
                    window_len = i_pwdata[7:0];
                else
                    no_obj_frac = i_pwdata[8:0];
            end
        end
        o_fail_count <= fail_total;
        o_pending <= decision_q.size();
        o_decisions <= decision_total;
    end

endmodule

@@ dv/windowed_class_majority_vote_tb.sv @@
// Testbench top that drives labels and register writes into the vote and gives the verdict.
`timescale 1ns / 1ps

module windowed_class_majority_vote_tb
    import wcmv_pkg::*;
;

    localparam int unsigned NUM_CLASSES = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    // Window of ten counted labels where class 3 and class 10 tie at three each.
    localparam logic [LABEL_W-1:0] TIE_WINDOW [10] = '{
        4'd10, 4'd10, 4'd3, 4'd3, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd10
    };

    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_label_seen = 1'b0;
    logic [LABEL_W-1:0]    i_class_label = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [DECIDED_W-1:0]  o_decided_class;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int          fail_count;
    int          pending_decisions;
    int          decisions_seen;
    int          sent_total = 0;
    int          reg_writes = 0;
    int          burst_left = 8;
    int          idle_cycles = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_tick = 0;

    always #1 i_clk = ~i_clk;

    windowed_class_majority_vote #(
        .NUM_CLASSES(NUM_CLASSES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_label_seen(i_label_seen),
        .i_class_label(i_class_label),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_decided_class(o_decided_class),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    windowed_class_majority_vote_checker #(
        .NUM_CLASSES(NUM_CLASSES)
    ) vote_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .i_in_stall(o_stall),
        .i_label_seen(i_label_seen),
        .i_class_label(i_class_label),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_decided_class(o_decided_class),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .i_pready(pready),
        .o_fail_count(fail_count),
        .o_pending(pending_decisions),
        .o_decisions(decisions_seen)
    );

    // The receiver switches between stall patterns at random intervals.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(30, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        unique case (stall_mode)
            STALL_NONE: i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_tick % 9) < 6);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: %0d cycles without any transaction", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Holds one label transaction until it is taken, then possibly ends the burst with a gap.
    task automatic send_label(input logic seen, input logic [LABEL_W-1:0] lbl);
        i_valid <= 1'b1;
        i_label_seen <= seen;
        i_class_label <= lbl;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sent_total++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Waits until every predicted decision has been taken and the block has gone quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_decisions != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [LABEL_W-1:0] pick_label(input logic [LABEL_W-1:0] favored);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return favored;
        if (roll < 55) return '0;
        if (roll < 88) return LABEL_W'($urandom_range(1, NUM_CLASSES - 1));
        return LABEL_W'($urandom_range(NUM_CLASSES, 15));
    endfunction

    task automatic run_phase(input logic [7:0] wl, input logic [8:0] frac, input int n_counted);
        int                 counted;
        logic               seen;
        logic [LABEL_W-1:0] lbl;
        logic [LABEL_W-1:0] favored;
        counted = 0;
        favored = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
        write_reg(REG_WINDOW_LENGTH, 32'(wl));
        write_reg(REG_NO_OBJ_FRAC, 32'(frac));
        while (counted < n_counted) begin
            // A favored class gives windows with a clear leader; it moves now and then.
            if ($urandom_range(0, 15) == 0)
                favored = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
            seen = ($urandom_range(0, 9) != 0);
            lbl = pick_label(favored);
            send_label(seen, lbl);
            if (seen && lbl < NUM_CLASSES) counted++;
        end
        settle();
    endtask

    initial begin : stimulus
        logic [8:0] frac;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: an unseen transaction and out-of-range labels change nothing,
        // then a tied window must go to the lower class.
        send_label(1'b0, 4'd15);
        for (int lbl = NUM_CLASSES; lbl <= 15; lbl++) send_label(1'b1, LABEL_W'(lbl));
        foreach (TIE_WINDOW[k]) send_label(1'b1, TIE_WINDOW[k]);
        send_label(1'b1, 4'd7);
        settle();

        // A zero-length window decides on every seen transaction.
        write_reg(REG_WINDOW_LENGTH, 32'd0);
        send_label(1'b1, 4'd0);
        send_label(1'b1, 4'd9);
        settle();

        // Shortening the window part way through ends it on the next seen transaction.
        write_reg(REG_WINDOW_LENGTH, 32'd8);
        write_reg(REG_NO_OBJ_FRAC, 32'd256);
        send_label(1'b1, 4'd0);
        send_label(1'b1, 4'd0);
        send_label(1'b1, 4'd0);
        send_label(1'b1, 4'd0);
        send_label(1'b1, 4'd6);
        settle();
        write_reg(REG_WINDOW_LENGTH, 32'd2);
        send_label(1'b1, 4'd6);
        settle();

        run_phase(8'd255, 9'd0, 270);
        run_phase(8'd0, 9'd256, 40);
        for (int p = 0; p < 10; p++) begin
            unique case (p % 4)
                0: frac = 9'd511;
                1: frac = 9'd0;
                2: frac = 9'd256;
                default: frac = 9'($urandom_range(0, 511));
            endcase
            run_phase((p == 0) ? 8'd1 : 8'($urandom_range(2, 12)), frac, 34);
        end

        repeat (16) @(posedge i_clk);
        $display("Run covered %0d label transactions, %0d register writes",
                 sent_total, reg_writes);
        $display("and %0d checked decisions.", decisions_seen);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found", fail_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
